>>> rtl/ialu_pkg.sv
package ialu_pkg;

	localparam int DataW  = 32;
	localparam int KindW  = 3;
	localparam int StatW  = 2;
	localparam int CountW = $clog2(DataW);

	localparam logic [KindW-1:0] KIND_ADD = 3'd0;
	localparam logic [KindW-1:0] KIND_SUB = 3'd1;
	localparam logic [KindW-1:0] KIND_MUL = 3'd2;
	localparam logic [KindW-1:0] KIND_DIV = 3'd3;
	localparam logic [KindW-1:0] KIND_REM = 3'd4;

	localparam logic [StatW-1:0] STAT_OK       = 2'd0;
	localparam logic [StatW-1:0] STAT_DIV_ZERO = 2'd1;
	localparam logic [StatW-1:0] STAT_BAD_OP   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALU,
		ST_NEG_A,
		ST_NEG_B,
		ST_ITER,
		ST_FIX,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [DataW-1:0] acc;
		logic [StatW-1:0] status;
	} result_t;

endpackage

>>> rtl/ialu_core.sv
module ialu_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [ialu_pkg::KindW-1:0] kind,
	input  logic [ialu_pkg::DataW-1:0] operand_a,
	input  logic [ialu_pkg::DataW-1:0] operand_b,
	output logic                    idle,
	output logic                    done,
	input  logic                    take,
	output ialu_pkg::result_t       result
);
	import ialu_pkg::*;

	state_t state_q, state_d;

	logic [KindW-1:0]  kind_q;
	logic [DataW-1:0]  a_q;
	logic [DataW-1:0]  b_q;
	logic [DataW-1:0]  rem_q;
	logic [DataW-1:0]  res_q;
	logic [DataW-1:0]  acc_q;
	logic [StatW-1:0]  status_q;
	logic              neg_q;
	logic [CountW-1:0] cnt_q;

	// shared adder / subtractor
	logic [DataW:0] add_x;
	logic [DataW:0] add_y;
	logic           add_sub;
	logic [DataW:0] add_sum;

	logic is_mul;
	logic last_iter;

	assign is_mul    = (kind_q == KIND_MUL);
	assign last_iter = (cnt_q == CountW'(DataW - 1));

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			ST_ALU: begin
				add_x   = {1'b0, a_q};
				add_y   = {1'b0, b_q};
				add_sub = (kind_q == KIND_SUB);
			end
			ST_NEG_A: begin
				add_y   = {1'b0, a_q};
				add_sub = 1'b1;
			end
			ST_NEG_B: begin
				add_y   = {1'b0, b_q};
				add_sub = 1'b1;
			end
			ST_ITER: begin
				if (is_mul) begin
					add_x = {1'b0, res_q};
					add_y = {1'b0, a_q};
				end else begin
					// trial subtract of the divisor from the shifted partial remainder
					add_x   = {rem_q, a_q[DataW-1]};
					add_y   = {1'b0, b_q};
					add_sub = 1'b1;
				end
			end
			ST_FIX: begin
				add_y   = {1'b0, (kind_q == KIND_DIV) ? a_q : rem_q};
				add_sub = 1'b1;
			end
			default: ;
		endcase
		add_sum = add_x + (add_sub ? ~add_y : add_y) + {{DataW{1'b0}}, add_sub};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (kind)
						KIND_ADD, KIND_SUB: state_d = ST_ALU;
						KIND_MUL:           state_d = ST_ITER;
						KIND_DIV, KIND_REM: state_d = (operand_b == '0) ? ST_DONE : ST_NEG_A;
						default:            state_d = ST_DONE;
					endcase
				end
			end
			ST_ALU:   state_d = ST_DONE;
			ST_NEG_A: state_d = ST_NEG_B;
			ST_NEG_B: state_d = ST_ITER;
			ST_ITER: begin
				if (last_iter) state_d = is_mul ? ST_DONE : ST_FIX;
			end
			ST_FIX:   state_d = ST_DONE;
			ST_DONE: begin
				if (take) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			acc_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ITER) cnt_q <= cnt_q + CountW'(1);
			else                    cnt_q <= '0;
			if (state_q == ST_DONE && take && status_q == STAT_OK) acc_q <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					kind_q <= kind;
					a_q    <= operand_a;
					b_q    <= operand_b;
					rem_q  <= '0;
					res_q  <= '0;
					neg_q  <= (kind == KIND_DIV) ? (operand_a[DataW-1] ^ operand_b[DataW-1])
					                              : operand_a[DataW-1];
					unique case (kind)
						KIND_ADD, KIND_SUB, KIND_MUL: status_q <= STAT_OK;
						KIND_DIV, KIND_REM:
							status_q <= (operand_b == '0) ? STAT_DIV_ZERO : STAT_OK;
						default: status_q <= STAT_BAD_OP;
					endcase
				end
			end
			ST_ALU: res_q <= add_sum[DataW-1:0];
			ST_NEG_A: begin
				if (a_q[DataW-1]) a_q <= add_sum[DataW-1:0];
			end
			ST_NEG_B: begin
				if (b_q[DataW-1]) b_q <= add_sum[DataW-1:0];
			end
			ST_ITER: begin
				if (is_mul) begin
					if (b_q[0]) res_q <= add_sum[DataW-1:0];
					a_q <= {a_q[DataW-2:0], 1'b0};
					b_q <= {1'b0, b_q[DataW-1:1]};
				end else if (!add_sum[DataW]) begin
					rem_q <= add_sum[DataW-1:0];
					a_q   <= {a_q[DataW-2:0], 1'b1};
				end else begin
					rem_q <= add_x[DataW-1:0];
					a_q   <= {a_q[DataW-2:0], 1'b0};
				end
			end
			ST_FIX: begin
				if (neg_q) res_q <= add_sum[DataW-1:0];
				else       res_q <= (kind_q == KIND_DIV) ? a_q : rem_q;
			end
			default: ;
		endcase
	end

	assign idle          = (state_q == ST_IDLE);
	assign done          = (state_q == ST_DONE);
	assign result.acc    = (status_q == STAT_OK) ? res_q : acc_q;
	assign result.status = status_q;

endmodule

>>> rtl/integer_alu_with_accumulator_unit.sv
// Signed 32-bit ALU with an accumulator: each input transaction carries an opcode
// (add, subtract, multiply, divide, remainder) and two operands, and yields one output
// transaction with the new accumulator value and a status code (division by zero and
// unknown opcodes leave the accumulator unchanged). All arithmetic runs through one
// shared 33-bit adder under a small sequencer: add and subtract take a single adder
// step, multiply one shift-add step per operand bit, divide and remainder one step each
// to take the magnitudes of a and b, one restoring step per quotient bit and one sign
// fixup; a zero divisor or an unknown opcode goes straight to its result. One item is
// in work at a time; the output register lets the next item start while an earlier
// result waits to be taken.
module integer_alu_with_accumulator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [31:0] operand_a, [63:32] operand_b
	input  logic [2:0]  s_axis_tuser,  // [2:0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] accumulator
	output logic [1:0]  m_axis_tuser   // [1:0] status
);
	import ialu_pkg::*;

	logic    core_idle;
	logic    core_done;
	logic    core_take;
	result_t core_result;
	logic    m_valid_q;
	result_t m_result_q;

	assign s_axis_tready = core_idle;
	assign core_take     = core_done && (!m_valid_q || m_axis_tready);

	ialu_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_axis_tvalid && core_idle),
		.kind      (s_axis_tuser),
		.operand_a (s_axis_tdata[DataW-1:0]),
		.operand_b (s_axis_tdata[2*DataW-1:DataW]),
		.idle      (core_idle),
		.done      (core_done),
		.take      (core_take),
		.result    (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (core_take) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_take) m_result_q <= core_result;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_result_q.acc;
	assign m_axis_tuser  = m_result_q.status;

endmodule

>>> rtl/ialu_checker.sv
module ialu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	import ialu_pkg::*;

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output transaction changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_DIV_ZERO ||
			m_axis_tuser == STAT_BAD_OP))
		else $error("undefined status code");

	// one item in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an item is in work");

	// no item finishes in the cycle after its acceptance
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result appeared too early");

endmodule

bind integer_alu_with_accumulator_unit ialu_checker u_ialu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

>>> bench/integer_alu_with_accumulator_unit_tb.sv
module integer_alu_with_accumulator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ialu_pkg::*;

	localparam logic [KindW-1:0] KIND_UNDEF_5 = 3'd5;
	localparam logic [KindW-1:0] KIND_UNDEF_6 = 3'd6;
	localparam logic [KindW-1:0] KIND_UNDEF_7 = 3'd7;

	localparam logic [DataW-1:0] MIN_VAL = 32'h8000_0000;
	localparam logic [DataW-1:0] MAX_VAL = 32'h7FFF_FFFF;
	localparam logic [DataW-1:0] NEG_ONE = 32'hFFFF_FFFF;

	localparam int RANDOM_OPS  = 1700;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 600000;

	class acc_scoreboard;
		logic [DataW-1:0] acc_now;
		result_t          pending_results[$];
		int               errors;

		function new();
			acc_now = '0;
			errors  = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// Apply one accepted operation to the accumulator and queue its result.
		function void note_op(logic [KindW-1:0] kind, logic [DataW-1:0] a, logic [DataW-1:0] b);
			logic [DataW-1:0] mag_a;
			logic [DataW-1:0] mag_b;
			logic [DataW-1:0] quo;
			logic [DataW-1:0] rem;
			logic [StatW-1:0] stat;
			result_t          res;
			stat = STAT_OK;
			case (kind)
				KIND_ADD: acc_now = a + b;
				KIND_SUB: acc_now = a - b;
				KIND_MUL: acc_now = a * b;
				KIND_DIV, KIND_REM: begin
					if (b == '0) begin
						stat = STAT_DIV_ZERO;
					end else begin
						mag_a = a[DataW-1] ? (~a + 32'd1) : a;
						mag_b = b[DataW-1] ? (~b + 32'd1) : b;
						quo   = mag_a / mag_b;
						rem   = mag_a % mag_b;
						if (kind == KIND_DIV)
							acc_now = (a[DataW-1] ^ b[DataW-1]) ? (~quo + 32'd1) : quo;
						else
							acc_now = a[DataW-1] ? (~rem + 32'd1) : rem;
					end
				end
				default: stat = STAT_BAD_OP;
			endcase
			res.acc    = acc_now;
			res.status = stat;
			pending_results.push_back(res);
		endfunction

		function void check_result(logic [DataW-1:0] acc, logic [StatW-1:0] stat);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: accumulator %h status %0d", acc, stat);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (acc !== want.acc) begin
				$error("accumulator: expected %h, actual %h", want.acc, acc);
				errors++;
			end
			if (stat !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, stat);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b1;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [63:0]       s_axis_tdata = '0;   // [31:0] operand_a, [63:32] operand_b
	logic [KindW-1:0]  s_axis_tuser = '0;   // [2:0] kind
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DataW-1:0]  m_axis_tdata;        // [31:0] accumulator
	logic [StatW-1:0]  m_axis_tuser;        // [1:0] status

	acc_scoreboard sb;
	bit            tx_quiet = 1'b0;
	bit            rx_quiet = 1'b0;
	int            cycles = 0;

	integer_alu_with_accumulator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Idle for a random gap, then offer one operation and hold it until the transaction.
	task automatic issue_op(input logic [KindW-1:0] kind, input logic [DataW-1:0] a,
			input logic [DataW-1:0] b);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, a};
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_op(kind, a, b);
	endtask

	function automatic logic [DataW-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom_range(0, 1) ? 32'd1 : NEG_ONE;
			2: return MIN_VAL;
			3: return MAX_VAL;
			4: return 32'($urandom_range(0, 32)) - 32'd16;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [KindW-1:0] pick_kind();
		int r;
		r = $urandom_range(0, 19);
		if (r < 17)
			return KindW'(r % 5);
		return KindW'(5 + $urandom_range(0, 2));
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// Result side: random stalls, quiet stretches, and one long hold-off.
	initial begin
		int  stall;
		int  taken;
		bit  held;
		taken = 0;
		held  = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 32 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			stall = rx_quiet ? 0 : $urandom_range(0, 14);
			if (!held && taken == HOLD_AT) begin
				stall = HOLD_CYCLES;
				held  = 1'b1;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			taken++;
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
		$display("[integer_alu_with_accumulator_unit] ERROR");
		$finish;
	end

	initial begin
		// drive a real falling edge so the asynchronous reset takes effect
		arst_n <= 1'b0;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Wraparound at the extremes.
		issue_op(KIND_ADD, MAX_VAL, MAX_VAL);
		issue_op(KIND_ADD, MIN_VAL, MIN_VAL);
		issue_op(KIND_ADD, MAX_VAL, 32'd1);
		issue_op(KIND_SUB, MIN_VAL, 32'd1);
		issue_op(KIND_SUB, 32'd0, MIN_VAL);
		issue_op(KIND_MUL, MAX_VAL, MAX_VAL);
		issue_op(KIND_MUL, MIN_VAL, NEG_ONE);
		issue_op(KIND_MUL, MIN_VAL, MIN_VAL);
		issue_op(KIND_MUL, NEG_ONE, NEG_ONE);
		// Minimum over minus one.
		issue_op(KIND_DIV, MIN_VAL, NEG_ONE);
		issue_op(KIND_REM, MIN_VAL, NEG_ONE);
		// Signs of truncated quotient and remainder.
		issue_op(KIND_DIV, 32'd7, 32'hFFFF_FFFE);
		issue_op(KIND_DIV, 32'hFFFF_FFF9, 32'd2);
		issue_op(KIND_REM, 32'hFFFF_FFF9, 32'd2);
		issue_op(KIND_REM, 32'd7, 32'hFFFF_FFFE);
		issue_op(KIND_DIV, 32'd3, MAX_VAL);
		issue_op(KIND_DIV, MIN_VAL, MIN_VAL);
		issue_op(KIND_REM, MAX_VAL, MIN_VAL);
		issue_op(KIND_DIV, MAX_VAL, 32'd1);
		// Divide by zero and bad opcodes keep a nonzero accumulator.
		issue_op(KIND_DIV, 32'd12345, 32'd0);
		issue_op(KIND_REM, MIN_VAL, 32'd0);
		issue_op(KIND_UNDEF_5, MAX_VAL, MIN_VAL);
		issue_op(KIND_UNDEF_6, NEG_ONE, NEG_ONE);
		issue_op(KIND_UNDEF_7, 32'd0, 32'd0);

		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (i % 64 == 0)
				tx_quiet = ($urandom_range(0, 3) == 0);
			issue_op(pick_kind(), pick_operand(), pick_operand());
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[integer_alu_with_accumulator_unit] OK");
		else
			$display("[integer_alu_with_accumulator_unit] ERROR");
		$finish;
	end

endmodule
